// ===== rtl/scd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scd_pkg
// Shared types, constants and helpers for the scaled decimal compare core.
// ----------------------------------------------------------------------------
package scd_pkg;

    localparam int MANTISSA_WORDS = 3;
    localparam int WIDE_WORDS     = 6;
    localparam int MAX_SCALE      = 28;

    localparam int WIDE_BITS = 32 * WIDE_WORDS;
    localparam int LOAD_BITS = 32 * ((MANTISSA_WORDS < 3) ? MANTISSA_WORDS : 3);
    localparam int SCALE_W   = $clog2(MAX_SCALE + 1);

    localparam logic [95:0] LOAD_MASK = {96{1'b1}} >> (96 - LOAD_BITS);

    typedef logic [WIDE_BITS-1:0] t_wide;
    typedef logic [SCALE_W-1:0]   t_scale;

    typedef struct packed {
        logic [63:0] first_mantissa_low;
        logic [31:0] first_mantissa_high;
        logic [4:0]  first_scale;
        logic        first_negative;
        logic [63:0] second_mantissa_low;
        logic [31:0] second_mantissa_high;
        logic [4:0]  second_scale;
        logic        second_negative;
    } t_in_word;

    typedef struct packed {
        logic is_less;
        logic is_less_or_equal;
        logic is_greater;
        logic is_greater_or_equal;
        logic is_equal;
        logic is_not_equal;
    } t_out_word;

    // magnitude relation between the two aligned operands
    typedef struct packed {
        logic lt;
        logic eq;
        logic gt;
    } t_rel;

    function automatic t_wide load_wide(input logic [63:0] low, input logic [31:0] high);
        logic [95:0]           src;
        logic [WIDE_BITS+95:0] tmp;
        src = {high, low} & LOAD_MASK;
        tmp = {{WIDE_BITS{1'b0}}, src};
        return tmp[WIDE_BITS-1:0];
    endfunction

    function automatic t_scale clamp_scale(input logic [4:0] s);
        if (int'(s) > MAX_SCALE) begin
            return SCALE_W'(MAX_SCALE);
        end
        return SCALE_W'(s);
    endfunction

    function automatic t_out_word rel_to_word(input t_rel r);
        t_out_word w;
        w.is_less             = r.lt;
        w.is_less_or_equal    = r.lt | r.eq;
        w.is_greater          = r.gt;
        w.is_greater_or_equal = r.gt | r.eq;
        w.is_equal            = r.eq;
        w.is_not_equal        = ~r.eq;
        return w;
    endfunction

endpackage

// ===== rtl/scd_times_ten.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scd_times_ten
// Shared scaling unit: multiplies a wide value by ten as a shift-and-add,
// kept modulo the buffer width.
// ----------------------------------------------------------------------------
module scd_times_ten import scd_pkg::*; (
    input  t_wide i_value,
    output t_wide o_value
);

    assign o_value = (i_value << 3) + (i_value << 1);

endmodule

// ===== rtl/scd_mag_cmp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scd_mag_cmp
// Unsigned magnitude compare of two aligned wide operands.
// ----------------------------------------------------------------------------
module scd_mag_cmp import scd_pkg::*; (
    input  t_wide i_a,
    input  t_wide i_b,
    output t_rel  o_rel
);

    always_comb begin
        o_rel.lt = (i_a < i_b);
        o_rel.gt = (i_a > i_b);
        o_rel.eq = (i_a == i_b);
    end

endmodule

// ===== rtl/scaled_decimal_compare_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scaled_decimal_compare_core
// Compares two scaled sign-magnitude decimals and reports all six relations.
// ----------------------------------------------------------------------------
// sequence: S_IDLE accepts a word, S_ALIGN scales the smaller-scale operand
// (skipped for equal scales, mixed signs or two zeros) on the shared x10 unit
// that runs one alignment step per cycle, then S_CMP writes the result word;
// it sits in an output register, so the next word may start meanwhile
// reset: synchronous active low, clears the sequencer and the result valid
module scaled_decimal_compare_core import scd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_word  i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_word o_data
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_ALIGN = 3'b010,
        S_CMP   = 3'b100
    } t_state;

    t_state    r_state, n_state;
    t_scale    r_diff, n_diff;
    logic      r_ovalid;
    t_wide     r_a, r_b;
    logic      r_sel_a;
    logic      r_fast;
    t_rel      r_fast_rel;
    logic      r_neg;
    t_out_word r_out;

    t_wide  ld_a, ld_b, unit_in, unit_out;
    t_scale sa, sb, diff_in;
    logic   in_acc, out_free, both_zero, sign_diff;
    t_rel   mag_rel, fin_rel, fast_rel;

    assign in_acc   = i_valid & ~o_stall;
    assign out_free = ~r_ovalid | ~i_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = r_ovalid;
    assign o_data   = r_out;

    always_comb begin
        ld_a      = load_wide(i_data.first_mantissa_low, i_data.first_mantissa_high);
        ld_b      = load_wide(i_data.second_mantissa_low, i_data.second_mantissa_high);
        sa        = clamp_scale(i_data.first_scale);
        sb        = clamp_scale(i_data.second_scale);
        diff_in   = (sa >= sb) ? (sa - sb) : (sb - sa);
        both_zero = (ld_a == '0) && (ld_b == '0);
        sign_diff = i_data.first_negative ^ i_data.second_negative;
        fast_rel.eq = both_zero;
        fast_rel.lt = ~both_zero & i_data.first_negative;
        fast_rel.gt = ~both_zero & ~i_data.first_negative;
    end

    assign unit_in = r_sel_a ? r_a : r_b;

    scd_times_ten u_times_ten (
        .i_value (unit_in),
        .o_value (unit_out)
    );

    scd_mag_cmp u_mag_cmp (
        .i_a   (r_a),
        .i_b   (r_b),
        .o_rel (mag_rel)
    );

    always_comb begin
        if (r_fast) begin
            fin_rel = r_fast_rel;
        end else if (r_neg) begin
            fin_rel.lt = mag_rel.gt;
            fin_rel.gt = mag_rel.lt;
            fin_rel.eq = mag_rel.eq;
        end else begin
            fin_rel = mag_rel;
        end
    end

    always_comb begin
        n_state = r_state;
        n_diff  = r_diff;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_diff = diff_in;
                    if (both_zero || sign_diff || (diff_in == '0)) begin
                        n_state = S_CMP;
                    end else begin
                        n_state = S_ALIGN;
                    end
                end
            end
            S_ALIGN: begin
                n_diff = r_diff - t_scale'(1);
                if (r_diff == t_scale'(1)) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_diff   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_diff  <= n_diff;
            if ((r_state == S_CMP) && out_free) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a        <= ld_a;
            r_b        <= ld_b;
            r_sel_a    <= (sa < sb);
            r_fast     <= both_zero | sign_diff;
            r_fast_rel <= fast_rel;
            r_neg      <= i_data.first_negative;
        end else if (r_state == S_ALIGN) begin
            if (r_sel_a) begin
                r_a <= unit_out;
            end else begin
                r_b <= unit_out;
            end
        end
        if ((r_state == S_CMP) && out_free) begin
            r_out <= rel_to_word(fin_rel);
        end
    end

endmodule

// ===== rtl/scd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scd_checker
// Port-level checks for the scaled decimal compare core, bound to the top.
// ----------------------------------------------------------------------------
module scd_checker import scd_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_valid,
    input logic      o_stall,
    input t_in_word  i_data,
    input logic      o_valid,
    input logic      i_stall,
    input t_out_word o_data
);

    // a result word that waits keeps its valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result valid dropped while stalled");

    // a stalled input word holds steady
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_data))
        else $error("input word changed while stalled");

    // one word in flight: the core is busy right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input not stalled after accept");

    // the six relations agree with each other
    a_rel_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.is_less != o_data.is_greater_or_equal) &&
                    (o_data.is_greater != o_data.is_less_or_equal) &&
                    (o_data.is_equal != o_data.is_not_equal) &&
                    ($countones({o_data.is_less, o_data.is_equal, o_data.is_greater}) == 1))
        else $error("inconsistent relation word");

    // reset leaves no result pending
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind scaled_decimal_compare_core scd_checker u_scd_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .i_data  (i_data),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for scaled_decimal_compare_core. A short table of
// operand pairs covers zeros of both signs, extreme mantissas and scales,
// mixed signs and aligned equal values. Random pairs follow, many of them
// the same value at two scales, or one unit apart, so the alignment path is
// exercised. Every result word is checked field by field against the
// table's expected word or an in-bench 192-bit predictor, under random gaps
// on the input and random stalls on the output.
// ----------------------------------------------------------------------------
module tb_top;
    import scd_pkg::*;

    localparam int RANDOM_WORDS = 1050;
    localparam int DRAIN_CYCLES = 40;
    localparam bit BY_MODEL     = 1'b0;
    localparam bit TYPED        = 1'b1;

    localparam logic [95:0] MANT_MAX = {96{1'b1}};

    // bit order: less, less_or_equal, greater, greater_or_equal, equal, not_equal
    localparam t_out_word REL_LESS    = 6'b110001;
    localparam t_out_word REL_EQUAL   = 6'b010110;
    localparam t_out_word REL_GREATER = 6'b001101;

    typedef struct {
        t_in_word  operands;
        bit        typed;
        t_out_word want;
    } t_stim_row;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_stall;
    t_in_word  i_data;
    logic      o_valid;
    logic      i_stall;
    t_out_word o_data;

    t_stim_row stim_rows[$];
    t_out_word expected_relations[$];
    int        mismatch_count = 0;
    bit        send_quiet = 1'b0;
    bit        recv_quiet = 1'b0;

    scaled_decimal_compare_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic logic [191:0] scale_up(input logic [191:0] v, input int steps);
        logic [191:0] acc;
        acc = v;
        for (int i = 0; i < steps; i++) begin
            acc = acc * 192'd10;
        end
        return acc;
    endfunction

    function automatic t_out_word predict_relation(input t_in_word w);
        logic [191:0] mag_a;
        logic [191:0] mag_b;
        int           sc_a;
        int           sc_b;
        int           rel;
        t_out_word    r;
        mag_a = {96'b0, w.first_mantissa_high, w.first_mantissa_low};
        mag_b = {96'b0, w.second_mantissa_high, w.second_mantissa_low};
        sc_a  = (int'(w.first_scale) > MAX_SCALE) ? MAX_SCALE : int'(w.first_scale);
        sc_b  = (int'(w.second_scale) > MAX_SCALE) ? MAX_SCALE : int'(w.second_scale);
        if (mag_a == '0 && mag_b == '0) begin
            rel = 0;
        end else if (w.first_negative != w.second_negative) begin
            rel = w.first_negative ? -1 : 1;
        end else begin
            if (sc_a < sc_b) begin
                mag_a = scale_up(mag_a, sc_b - sc_a);
            end else begin
                mag_b = scale_up(mag_b, sc_a - sc_b);
            end
            rel = (mag_a > mag_b) ? 1 : ((mag_a < mag_b) ? -1 : 0);
            if (w.first_negative) begin
                rel = -rel;
            end
        end
        r.is_less             = (rel < 0);
        r.is_less_or_equal    = (rel <= 0);
        r.is_greater          = (rel > 0);
        r.is_greater_or_equal = (rel >= 0);
        r.is_equal            = (rel == 0);
        r.is_not_equal        = (rel != 0);
        return r;
    endfunction

    function automatic t_in_word pack_operands(input logic [95:0] ma, input int sa,
                                               input bit na, input logic [95:0] mb,
                                               input int sb, input bit nb);
        t_in_word w;
        w.first_mantissa_low   = ma[63:0];
        w.first_mantissa_high  = ma[95:64];
        w.first_scale          = 5'(sa);
        w.first_negative       = na;
        w.second_mantissa_low  = mb[63:0];
        w.second_mantissa_high = mb[95:64];
        w.second_scale         = 5'(sb);
        w.second_negative      = nb;
        return w;
    endfunction

    task automatic add_row(input logic [95:0] ma, input int sa, input bit na,
                           input logic [95:0] mb, input int sb, input bit nb,
                           input bit typed, input t_out_word want);
        t_stim_row row;
        row.operands = pack_operands(ma, sa, na, mb, sb, nb);
        row.typed    = typed;
        row.want     = want;
        stim_rows.push_back(row);
    endtask

    function automatic logic [95:0] random_mantissa();
        logic [95:0] full;
        full = {$urandom, $urandom, $urandom};
        case ($urandom_range(0, 7))
            0: begin
                return '0;
            end
            1: begin
                return MANT_MAX;
            end
            2: begin
                return 96'($urandom_range(0, 1000));
            end
            3: begin
                return 96'd1 << $urandom_range(0, 95);
            end
            4, 5: begin
                return full;
            end
            default: begin
                return full >> $urandom_range(0, 95);
            end
        endcase
    endfunction

    function automatic t_in_word random_operands();
        logic [95:0]  ma;
        logic [95:0]  mb;
        logic [191:0] wide;
        int           sa;
        int           sb;
        int           k;
        bit           na;
        bit           nb;
        ma = random_mantissa();
        sa = $urandom_range(0, MAX_SCALE);
        na = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 9) < 6) begin
            // same value at an equal or larger scale, possibly nudged by one unit
            k    = $urandom_range(0, MAX_SCALE - sa);
            wide = scale_up({96'b0, ma}, k);
            while (wide[191:96] != '0) begin
                k    = k - 1;
                wide = scale_up({96'b0, ma}, k);
            end
            mb = wide[95:0];
            sb = sa + k;
            case ($urandom_range(0, 3))
                0: begin
                    if (mb != MANT_MAX) mb = mb + 96'd1;
                end
                1: begin
                    if (mb != '0) mb = mb - 96'd1;
                end
                default: begin
                end
            endcase
            nb = ($urandom_range(0, 3) == 0) ? !na : na;
        end else begin
            mb = random_mantissa();
            sb = $urandom_range(0, MAX_SCALE);
            nb = 1'($urandom_range(0, 1));
        end
        if ($urandom_range(0, 1)) begin
            return pack_operands(mb, sb, nb, ma, sa, na);
        end
        return pack_operands(ma, sa, na, mb, sb, nb);
    endfunction

    function automatic int draw_wait(input bit quiet);
        return quiet ? 0 : int'($urandom_range(0, 14));
    endfunction

    task automatic send_word(input t_in_word w, input bit typed, input t_out_word want);
        int gap;
        gap = draw_wait(send_quiet);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= w;
        do @(posedge i_clk); while (o_stall);
        expected_relations.push_back(typed ? want : predict_relation(w));
    endtask

    task automatic check_field(input string name, input logic want, input logic got);
        if (got !== want) begin
            $error("%s mismatch: expected %0b, actual %0b", name, want, got);
            mismatch_count++;
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // result side
    initial begin
        int        stall_len;
        int        results_seen;
        t_out_word want;
        i_stall      = 1'b0;
        results_seen = 0;
        forever begin
            stall_len = draw_wait(recv_quiet);
            if (stall_len > 0) begin
                i_stall <= 1'b1;
                repeat (stall_len) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_valid && i_rst_n));
            if (expected_relations.size() == 0) begin
                $error("unexpected result word %b", o_data);
                mismatch_count++;
            end else begin
                want = expected_relations.pop_front();
                check_field("is_less", want.is_less, o_data.is_less);
                check_field("is_less_or_equal", want.is_less_or_equal,
                            o_data.is_less_or_equal);
                check_field("is_greater", want.is_greater, o_data.is_greater);
                check_field("is_greater_or_equal", want.is_greater_or_equal,
                            o_data.is_greater_or_equal);
                check_field("is_equal", want.is_equal, o_data.is_equal);
                check_field("is_not_equal", want.is_not_equal, o_data.is_not_equal);
            end
            results_seen++;
            if (results_seen % 64 == 0) begin
                recv_quiet = ($urandom_range(0, 3) == 0);
            end
        end
    end

    // operand side
    initial begin
        i_valid = 1'b0;
        i_data  = '0;

        // zeros of both signs
        add_row('0, 0, 1'b0, '0, 28, 1'b1, TYPED, REL_EQUAL);
        add_row('0, 28, 1'b1, '0, 5, 1'b0, TYPED, REL_EQUAL);
        add_row('0, 0, 1'b0, 96'd1, 0, 1'b1, TYPED, REL_GREATER);
        add_row('0, 3, 1'b1, 96'd1, 28, 1'b0, TYPED, REL_LESS);
        // extreme mantissas and scales
        add_row(MANT_MAX, 0, 1'b0, MANT_MAX, 0, 1'b0, TYPED, REL_EQUAL);
        add_row(MANT_MAX, 0, 1'b1, MANT_MAX, 0, 1'b1, TYPED, REL_EQUAL);
        add_row(MANT_MAX, 0, 1'b0, MANT_MAX, 0, 1'b1, TYPED, REL_GREATER);
        add_row(MANT_MAX, 28, 1'b1, '0, 0, 1'b0, TYPED, REL_LESS);
        add_row(MANT_MAX, 0, 1'b0, MANT_MAX, 28, 1'b0, TYPED, REL_GREATER);
        add_row(MANT_MAX, 0, 1'b1, MANT_MAX, 28, 1'b1, TYPED, REL_LESS);
        add_row(96'hFFFFFFFF_00000000_00000000, 0, 1'b0,
                96'h00000000_FFFFFFFF_FFFFFFFF, 0, 1'b0, TYPED, REL_GREATER);
        // signs and plain ordering at equal scale
        add_row(96'd3, 0, 1'b0, 96'd3, 0, 1'b1, TYPED, REL_GREATER);
        add_row(96'd2, 0, 1'b0, 96'd1, 0, 1'b0, TYPED, REL_GREATER);
        add_row(96'd1, 0, 1'b1, 96'd2, 0, 1'b1, TYPED, REL_GREATER);
        // alignment across scales
        add_row(96'd1, 0, 1'b0, 96'd10, 1, 1'b0, BY_MODEL, '0);
        add_row(96'd1, 0, 1'b0, 96'd10000000000, 10, 1'b0, BY_MODEL, '0);
        add_row(96'd1, 28, 1'b0, '0, 0, 1'b0, BY_MODEL, '0);
        add_row(96'd5, 1, 1'b1, 96'd50, 2, 1'b1, BY_MODEL, '0);
        add_row(96'd51, 2, 1'b1, 96'd5, 1, 1'b1, BY_MODEL, '0);
        add_row(MANT_MAX, 27, 1'b0, MANT_MAX, 28, 1'b0, BY_MODEL, '0);
        add_row(96'd123, 2, 1'b0, 96'd1229, 3, 1'b0, BY_MODEL, '0);
        add_row(96'd9999999999999999999999999999, 28, 1'b0, 96'd1, 0, 1'b0,
                BY_MODEL, '0);
        add_row(96'd10000000000000000000000000000, 28, 1'b1, 96'd1, 0, 1'b1,
                BY_MODEL, '0);

        do @(posedge i_clk); while (!i_rst_n);

        foreach (stim_rows[i]) begin
            send_word(stim_rows[i].operands, stim_rows[i].typed, stim_rows[i].want);
        end

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % 100 == 0) begin
                send_quiet = ($urandom_range(0, 3) == 0);
            end
            send_word(random_operands(), BY_MODEL, '0);
        end
        i_valid <= 1'b0;

        while (expected_relations.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/scd_pkg.sv
rtl/scd_times_ten.sv
rtl/scd_mag_cmp.sv
rtl/scaled_decimal_compare_core.sv
rtl/scd_checker.sv
verif/tb_top.sv
